// ----- hdl/rtte_pkg.sv -----
// Shared types, codes, reset values and fixed-point helper for the RTT estimator.
package rtte_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned GAIN_W    = 9;
  localparam int unsigned EXP_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 43;

  localparam logic [GAIN_W-1:0]  MEAN_GAIN_RST   = 9'd32;
  localparam logic [GAIN_W-1:0]  DEV_GAIN_RST    = 9'd64;
  localparam logic [FIELD_W-1:0] MIN_TIMEOUT_RST = 32'd200000;
  localparam logic [FIELD_W-1:0] MAX_TIMEOUT_RST = 32'd60000000;
  localparam logic [EXP_W-1:0]   MAX_EXP_RST     = 3'd6;
  localparam logic [FIELD_W-1:0] INIT_RTT_RST    = 32'd1000000;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_RESET   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_GAIN   = 3'd0,
    CFG_DEV_GAIN    = 3'd1,
    CFG_MIN_TIMEOUT = 3'd2,
    CFG_MAX_TIMEOUT = 3'd3,
    CFG_MAX_EXP     = 3'd4,
    CFG_INIT_RTT    = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_DIFF,
    ST_DEV,
    ST_MUL,
    ST_ADJ,
    ST_RTO_START,
    ST_RTO_WAIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [FIELD_W-1:0] srtt;
    logic [FIELD_W-1:0] dev;
    logic [FIELD_W-1:0] min_to;
    logic [FIELD_W-1:0] max_to;
    logic [EXP_W-1:0]   exp;
  } rto_req_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] value;
  } rto_rsp_t;

  // Adds trunc(prod / 256), rounded toward zero, to cur and saturates to 32 bits.
  function automatic logic [FIELD_W-1:0] gain_apply(input logic [FIELD_W-1:0] cur,
                                                     input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W:0]   sum;
    logic [FIELD_W-1:0]       res;
    adj = prod[PROD_W-1] ? (prod + 43'sd255) : prod;
    sum = $signed({11'd0, cur}) + 44'(adj >>> 8);
    if (sum[PROD_W]) begin
      res = '0;
    end else if (|sum[PROD_W-1:FIELD_W]) begin
      res = '1;
    end else begin
      res = sum[FIELD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/rtte_rto.sv -----
// Two-stage retransmit timeout unit: floor, backoff shift and ceiling.
module rtte_rto
  import rtte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rto_req_t req,
  output rto_rsp_t rsp
);

  logic                  stg_r;
  logic                  vld_r;
  logic [FIELD_W+2:0]    base_r, base_nxt;
  logic [FIELD_W-1:0]    max_r;
  logic [EXP_W-1:0]      exp_r;
  logic [FIELD_W-1:0]    value_r, value_nxt;
  logic [FIELD_W+2:0]    sum;
  logic [FIELD_W+9:0]    shifted;

  // Stage one: srtt + 4*dev, raised to the floor.
  always_comb begin
    sum      = 35'(req.srtt) + {1'b0, req.dev, 2'b00};
    base_nxt = (sum < 35'(req.min_to)) ? 35'(req.min_to) : sum;
  end

  // Stage two: apply the backoff multiplier and clip to the ceiling.
  always_comb begin
    shifted   = 42'(base_r) << exp_r;
    value_nxt = (shifted > 42'(max_r)) ? max_r : shifted[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      stg_r <= req.start;
      if (req.start) begin
        vld_r <= 1'b0;
      end else if (stg_r) begin
        vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      base_r <= base_nxt;
      max_r  <= req.max_to;
      exp_r  <= req.exp;
    end
    if (stg_r) begin
      value_r <= value_nxt;
    end
  end

  assign rsp.valid = vld_r;
  assign rsp.value = value_r;

endmodule

// ----- hdl/rtt_estimator_with_rto.sv -----
// Top level of the RTT estimator: outstanding-send table, estimator and result register.
// Timeout and reset events pass straight to the timeout unit; send and ack events first scan
// the table; an ack that seeds the estimate adds the difference step, and one that refines it
// also adds the deviation, multiplication and accumulate steps before the timeout. One event
// is in work at a time; the next is taken the cycle after its result enters the output
// register. The scan of the table memory, one entry per cycle through its single read port,
// sets the rate. Reset is synchronous, active low: it empties the table at once via
// per-entry valid flip-flops and loads register defaults.
module rtt_estimator_with_rto
  import rtte_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [FIELD_W-1:0]   in_seq_num,
  input  logic [FIELD_W-1:0]   in_now_us,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_sample_taken,
  output logic [FIELD_W-1:0]   out_measured_rtt_us,
  output logic [FIELD_W-1:0]   out_timeout_us,
  output logic                 out_table_full_drop,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = FIELD_W + TIME_WIDTH + 1;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. The port never back-pressures; writes to indexes past the
  // list are dropped.
  // ---------------------------------------------------------------------------------------
  logic [GAIN_W-1:0]  mean_gain_r;
  logic [GAIN_W-1:0]  dev_gain_r;
  logic [FIELD_W-1:0] min_timeout_r;
  logic [FIELD_W-1:0] max_timeout_r;
  logic [EXP_W-1:0]   max_exp_r;
  logic [FIELD_W-1:0] init_rtt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_gain_r   <= MEAN_GAIN_RST;
      dev_gain_r    <= DEV_GAIN_RST;
      min_timeout_r <= MIN_TIMEOUT_RST;
      max_timeout_r <= MAX_TIMEOUT_RST;
      max_exp_r     <= MAX_EXP_RST;
      init_rtt_r    <= INIT_RTT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MEAN_GAIN:   mean_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_DEV_GAIN:    dev_gain_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_MIN_TIMEOUT: min_timeout_r <= cfg_wdata;
        CFG_MAX_TIMEOUT: max_timeout_r <= cfg_wdata;
        CFG_MAX_EXP:     max_exp_r     <= cfg_wdata[EXP_W-1:0];
        CFG_INIT_RTT:    init_rtt_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Table memory. Each word holds the sequence number, the send time and the retransmitted
  // mark. Validity is kept in flip-flops beside it so that a reset event empties the table
  // at once. Only one event is in work at a time and its single write lands after the scan
  // has finished, so reads and writes never overlap on an entry and no forwarding path is
  // needed.
  // ---------------------------------------------------------------------------------------
  logic [ENT_W-1:0]       mem [TABLE_DEPTH];
  logic [ENT_W-1:0]       mem_q;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENT_W-1:0]       wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  logic [FIELD_W-1:0]    rd_seq;
  logic [TIME_WIDTH-1:0] rd_time;
  logic                  rd_retx;

  assign rd_seq  = mem_q[ENT_W-1 -: FIELD_W];
  assign rd_time = mem_q[TIME_WIDTH:1];
  assign rd_retx = mem_q[0];

  // ---------------------------------------------------------------------------------------
  // Control and working registers.
  // ---------------------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic                   hit_retx_r, hit_retx_nxt;
  logic [TIME_WIDTH-1:0]  hit_time_r, hit_time_nxt;
  logic                   free_r, free_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;

  req_type_t              req_r, req_nxt;
  logic [FIELD_W-1:0]     seq_r, seq_nxt;
  logic [TIME_WIDTH-1:0]  now_r, now_nxt;

  logic [FIELD_W-1:0]     srtt_r, srtt_nxt;
  logic [FIELD_W-1:0]     dev_r, dev_nxt;
  logic                   have_r, have_nxt;
  logic [EXP_W-1:0]       exp_r, exp_nxt;

  logic                   taken_r, taken_nxt;
  logic                   drop_r, drop_nxt;
  logic [FIELD_W-1:0]     meas_r, meas_nxt;
  logic signed [FIELD_W:0]    err_r, err_nxt;
  logic [FIELD_W-1:0]         aerr_r, aerr_nxt;
  logic signed [FIELD_W:0]    derr_r, derr_nxt;
  logic signed [PROD_W-1:0]   pm_r, pm_nxt;
  logic signed [PROD_W-1:0]   pd_r, pd_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_taken_r, out_drop_r;
  logic [FIELD_W-1:0]     out_meas_r, out_rto_r;
  logic                   out_load;

  logic                   in_accept;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [63:0]            elapsed_ext;

  rto_req_t               rto_req;
  rto_rsp_t               rto_rsp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Elapsed time wraps at the time width, then saturates to a 32-bit result.
  assign elapsed     = now_r - hit_time_r;
  assign elapsed_ext = 64'(elapsed);

  // The timeout unit always sees the live estimator state; it samples on start.
  assign rto_req.start  = (state_r == ST_RTO_START);
  assign rto_req.srtt   = srtt_r;
  assign rto_req.dev    = dev_r;
  assign rto_req.min_to = min_timeout_r;
  assign rto_req.max_to = max_timeout_r;
  assign rto_req.exp    = exp_r;

  rtte_rto u_rto (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rto_req),
    .rsp   (rto_rsp)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer. Send and ack events sweep the whole table, one read per cycle, recording the
  // matching entry (there is never more than one valid entry per sequence number) and the
  // first free slot. The update then runs as a short chain of registered steps: difference,
  // deviation error, the two gain multiplications and the saturating accumulate.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_retx_nxt = hit_retx_r;
    hit_time_nxt = hit_time_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    req_nxt      = req_r;
    seq_nxt      = seq_r;
    now_nxt      = now_r;
    srtt_nxt     = srtt_r;
    dev_nxt      = dev_r;
    have_nxt     = have_r;
    exp_nxt      = exp_r;
    taken_nxt    = taken_r;
    drop_nxt     = drop_r;
    meas_nxt     = meas_r;
    err_nxt      = err_r;
    aerr_nxt     = aerr_r;
    derr_nxt     = derr_r;
    pm_nxt       = pm_r;
    pd_nxt       = pd_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = hit_idx_r;
    wr_data      = {seq_r, hit_time_r, 1'b1};
    out_load     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt   = req_type_t'(in_req_type);
          seq_nxt   = in_seq_num;
          now_nxt   = TIME_WIDTH'(64'(in_now_us));
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          taken_nxt = 1'b0;
          drop_nxt  = 1'b0;
          meas_nxt  = '0;
          idx_nxt   = '0;
          if (in_req_type inside {REQ_SEND, REQ_ACK}) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_SCAN: begin
        if (idx_r != CNT_W'(TABLE_DEPTH)) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (valid_r[cmp_idx_r] && (rd_seq == seq_r)) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = cmp_idx_r;
            hit_retx_nxt = rd_retx;
            hit_time_nxt = rd_time;
          end
          if (!valid_r[cmp_idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (cmp_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RTO_START;
        case (req_r)
          REQ_SEND: begin
            if (hit_r) begin
              // Resent while outstanding: mark it so its ack is not timed.
              wr_en = 1'b1;
            end else if (free_r) begin
              wr_en              = 1'b1;
              wr_addr            = free_idx_r;
              wr_data            = {seq_r, now_r, 1'b0};
              valid_nxt[free_idx_r] = 1'b1;
            end else begin
              drop_nxt = 1'b1;
            end
          end
          REQ_ACK: begin
            if (hit_r) begin
              valid_nxt[hit_idx_r] = 1'b0;
              if (!hit_retx_r) begin
                taken_nxt = 1'b1;
                meas_nxt  = (|elapsed_ext[63:FIELD_W]) ? '1 : elapsed_ext[FIELD_W-1:0];
                exp_nxt   = '0;
                state_nxt = ST_DIFF;
              end
            end
          end
          REQ_TIMEOUT: begin
            exp_nxt = (exp_r >= max_exp_r) ? max_exp_r : (exp_r + 1'b1);
          end
          REQ_RESET: begin
            srtt_nxt  = init_rtt_r;
            dev_nxt   = '0;
            have_nxt  = 1'b0;
            exp_nxt   = '0;
            valid_nxt = '0;
          end
          default: ;
        endcase
      end

      ST_DIFF: begin
        if (have_r) begin
          err_nxt   = $signed({1'b0, meas_r}) - $signed({1'b0, srtt_r});
          aerr_nxt  = (meas_r >= srtt_r) ? (meas_r - srtt_r) : (srtt_r - meas_r);
          state_nxt = ST_DEV;
        end else begin
          // First measurement seeds the estimate directly.
          srtt_nxt  = meas_r;
          dev_nxt   = meas_r >> 1;
          have_nxt  = 1'b1;
          state_nxt = ST_RTO_START;
        end
      end

      ST_DEV: begin
        derr_nxt  = $signed({1'b0, aerr_r}) - $signed({1'b0, dev_r});
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        pm_nxt    = err_r * $signed({1'b0, mean_gain_r});
        pd_nxt    = derr_r * $signed({1'b0, dev_gain_r});
        state_nxt = ST_ADJ;
      end

      ST_ADJ: begin
        srtt_nxt  = gain_apply(srtt_r, pm_r);
        dev_nxt   = gain_apply(dev_r, pd_r);
        have_nxt  = 1'b1;
        state_nxt = ST_RTO_START;
      end

      ST_RTO_START: begin
        state_nxt = ST_RTO_WAIT;
      end

      ST_RTO_WAIT: begin
        if (rto_rsp.valid && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: frees the sequencer as soon as the result is parked here.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      srtt_r      <= '0;
      dev_r       <= '0;
      have_r      <= 1'b0;
      exp_r       <= '0;
      taken_r     <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      srtt_r      <= srtt_nxt;
      dev_r       <= dev_nxt;
      have_r      <= have_nxt;
      exp_r       <= exp_nxt;
      taken_r     <= taken_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_retx_r <= hit_retx_nxt;
    hit_time_r <= hit_time_nxt;
    free_idx_r <= free_idx_nxt;
    req_r      <= req_nxt;
    seq_r      <= seq_nxt;
    now_r      <= now_nxt;
    meas_r     <= meas_nxt;
    err_r      <= err_nxt;
    aerr_r     <= aerr_nxt;
    derr_r     <= derr_nxt;
    pm_r       <= pm_nxt;
    pd_r       <= pd_nxt;
    if (out_load) begin
      out_taken_r <= taken_r;
      out_drop_r  <= drop_r;
      out_meas_r  <= meas_r;
      out_rto_r   <= rto_rsp.value;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_taken    = out_taken_r;
  assign out_measured_rtt_us = out_meas_r;
  assign out_timeout_us      = out_rto_r;
  assign out_table_full_drop = out_drop_r;

endmodule

// ----- hdl/rtte_checker.sv -----
// Port-level checker for the RTT estimator and its bind to the top level.
module rtte_checker
  import rtte_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_sample_taken,
  input logic [FIELD_W-1:0]   out_measured_rtt_us,
  input logic [FIELD_W-1:0]   out_timeout_us,
  input logic                 out_table_full_drop
);

  // Only one event is in work: an accepted transaction closes the input next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted a second transaction while one was in work");

  // A result that is not a sample reports no measurement.
  a_meas_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_taken) |-> (out_measured_rtt_us == '0))
    else $error("measurement reported without a sample");

  // A sample comes only from an ack, a drop only from a send.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sample_taken && out_table_full_drop))
    else $error("sample and drop flagged on the same result");

  // A stalled result stays presented with its timeout unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_timeout_us)))
    else $error("stalled result changed or vanished");

endmodule

bind rtt_estimator_with_rto rtte_checker u_rtte_checker (.*);
